/* rtl/pap_pkg.sv */
`timescale 1ns / 1ps

package pap_pkg;

    localparam int MUL_BITS   = 32;
    localparam int PROD_BITS  = 2 * MUL_BITS;
    localparam int MPP_BITS   = 24;
    localparam int CROSS_BITS = 64;
    localparam int LEN_BITS   = 48;
    localparam int AREA_BITS  = 63;
    localparam int VCNT_BITS  = 16;
    localparam int ACC_BITS   = 112;

    localparam logic [MPP_BITS-1:0] MPP_RESET = 24'd65536;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

endpackage

/* rtl/pap_mul.sv */
`timescale 1ns / 1ps

module pap_mul (
    input  logic                           aclk,
    input  logic [pap_pkg::MUL_BITS-1:0]   a,
    input  logic [pap_pkg::MUL_BITS-1:0]   b,
    output logic [pap_pkg::PROD_BITS-1:0]  prod
);

    logic [pap_pkg::PROD_BITS-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= pap_pkg::PROD_BITS'(a) * pap_pkg::PROD_BITS'(b);
    end

    assign prod = prod_reg;

endmodule

/* rtl/pap_isqrt.sv */
`timescale 1ns / 1ps

module pap_isqrt #(
    parameter int ROOT_BITS = 25
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [2*ROOT_BITS-1:0]  radicand,
    output pap_pkg::sqrt_stat_t     stat,
    output logic [ROOT_BITS-1:0]    root
);

    localparam int CNT_W = $clog2(ROOT_BITS + 1);
    localparam int REM_W = ROOT_BITS + 3;

    logic [2*ROOT_BITS-1:0] rad_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[2*ROOT_BITS-1 -: 2]};
        trial  = REM_W'({root_reg, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_BITS);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[ROOT_BITS-2:0], fits};
                rad_reg  <= rad_reg << 2;
                cnt_reg  <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

/* rtl/polygon_area_perimeter.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// cfg       in         cfg_wr_en          cfg_wr_data (microns per pixel, Q8.16)
// s_        in         s_valid / s_ready  s_vertex_x, s_vertex_y, s_last_vertex
// m_        out        m_valid / m_ready  m_area_um2, m_perimeter_um, m_vertex_count
//
// First vertex of a contour that is not the last: taken while s_ready stays high. Any other vertex:
// s_ready low from acceptance through four shared-multiplier passes, then the bit-serial root.
// Last vertex: one more such edge pass for the closing edge (the only pass on a
// one-vertex contour), then scaling through the same multiplier; s_ready stays low.
// A pending result does not block input; the final step holds until the result slot is free.
// Reset (aresetn low, synchronous) clears the contour state and sets the scale to 1.0.

module polygon_area_perimeter #(
    parameter int COORD_BITS = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pap_pkg::MPP_BITS-1:0]      cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [COORD_BITS-1:0]             s_vertex_x,
    input  logic [COORD_BITS-1:0]             s_vertex_y,
    input  logic                              s_last_vertex,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pap_pkg::AREA_BITS-1:0]     m_area_um2,
    output logic [pap_pkg::LEN_BITS-1:0]      m_perimeter_um,
    output logic [pap_pkg::VCNT_BITS-1:0]     m_vertex_count
);

    localparam int PROD_W = 2 * COORD_BITS;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int RB     = COORD_BITS + 1;
    localparam int MB     = pap_pkg::MUL_BITS;
    localparam int CB     = pap_pkg::CROSS_BITS;
    localparam int LB     = pap_pkg::LEN_BITS;
    localparam int AB     = pap_pkg::ACC_BITS;

    localparam logic [CB-1:0] SIGN_BIT = {1'b1, {(CB-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EP,
        ST_EQ,
        ST_EDX,
        ST_EDY,
        ST_ESQ,
        ST_ESTART,
        ST_EWAIT,
        ST_FM2,
        ST_FM2W,
        ST_FA0,
        ST_FA1,
        ST_FA2,
        ST_FA3,
        ST_FA4,
        ST_FP0,
        ST_FP1,
        ST_FP2,
        ST_FOUT
    } state_t;

    state_t state_reg;

    logic [pap_pkg::MPP_BITS-1:0] mpp_reg;
    logic [COORD_BITS-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic [COORD_BITS-1:0] ea_x_reg, ea_y_reg, eb_x_reg, eb_y_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic                  last_reg;
    logic                  close_reg;
    logic [CB-1:0]         cross_sum_reg;
    logic [LB-1:0]         length_sum_reg;
    logic [COUNT_BITS-1:0] count_seen_reg;
    logic [PROD_W-1:0]     p_reg;
    logic                  neg_reg;
    logic [CB-1:0]         dmag_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [CB-1:0]         amag_reg;
    logic [47:0]           m2_reg;
    logic [AB-1:0]         acc_reg;
    logic                  acc_en_reg;
    logic [1:0]            shift_reg;
    logic [pap_pkg::AREA_BITS-1:0] area_res_reg;

    logic                          m_valid_reg;
    logic [pap_pkg::AREA_BITS-1:0] m_area_reg;
    logic [LB-1:0]                 m_perim_reg;
    logic [pap_pkg::VCNT_BITS-1:0] m_count_reg;

    logic [MB-1:0]                 mul_a, mul_b;
    logic [pap_pkg::PROD_BITS-1:0] prod;
    logic                          acc_en_next;
    logic [1:0]                    shift_next;
    logic                          sqrt_start;
    pap_pkg::sqrt_stat_t           sqrt_stat;
    logic [RB-1:0]                 root;

    logic [PROD_W-1:0] q_val;
    logic [PROD_W-1:0] pq_mag;
    logic              pq_neg;
    logic [CB-1:0]     cross_u;
    logic [CB:0]       cross_sub, cross_add;
    logic [CB-1:0]     cross_res;
    logic [LB:0]       len_add;
    logic [127:0]      acc_add;
    logic [31:0]       cnt_wide;

    pap_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pap_isqrt #(
        .ROOT_BITS (RB)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand ((2*RB)'(sq_reg)),
        .stat     (sqrt_stat),
        .root     (root)
    );

    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        acc_en_next = 1'b0;
        shift_next  = 2'd0;
        case (state_reg)
            ST_EP: begin
                mul_a = MB'(ea_x_reg);
                mul_b = MB'(eb_y_reg);
            end
            ST_EQ: begin
                mul_a = MB'(eb_x_reg);
                mul_b = MB'(ea_y_reg);
            end
            ST_EDX: begin
                mul_a = MB'(dx_reg);
                mul_b = MB'(dx_reg);
            end
            ST_EDY: begin
                mul_a = MB'(dy_reg);
                mul_b = MB'(dy_reg);
            end
            ST_FM2: begin
                mul_a = MB'(mpp_reg);
                mul_b = MB'(mpp_reg);
            end
            ST_FA0: begin
                mul_a       = amag_reg[31:0];
                mul_b       = m2_reg[31:0];
                acc_en_next = 1'b1;
            end
            ST_FA1: begin
                mul_a       = amag_reg[31:0];
                mul_b       = MB'(m2_reg[47:32]);
                acc_en_next = 1'b1;
                shift_next  = 2'd1;
            end
            ST_FA2: begin
                mul_a       = amag_reg[63:32];
                mul_b       = m2_reg[31:0];
                acc_en_next = 1'b1;
                shift_next  = 2'd1;
            end
            ST_FA3: begin
                mul_a       = amag_reg[63:32];
                mul_b       = MB'(m2_reg[47:32]);
                acc_en_next = 1'b1;
                shift_next  = 2'd2;
            end
            ST_FP0: begin
                mul_a       = length_sum_reg[31:0];
                mul_b       = MB'(mpp_reg);
                acc_en_next = 1'b1;
            end
            ST_FP1: begin
                mul_a       = MB'(length_sum_reg[47:32]);
                mul_b       = MB'(mpp_reg);
                acc_en_next = 1'b1;
                shift_next  = 2'd1;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        sqrt_start = (state_reg == ST_ESTART);
        q_val      = prod[PROD_W-1:0];
        pq_neg     = (p_reg < q_val);
        pq_mag     = pq_neg ? (q_val - p_reg) : (p_reg - q_val);
        cross_u    = cross_sum_reg ^ SIGN_BIT;
        cross_sub  = {1'b0, cross_u} - {1'b0, dmag_reg};
        cross_add  = {1'b0, cross_u} + {1'b0, dmag_reg};
        if (neg_reg) begin
            cross_res = cross_sub[CB] ? '0 : cross_sub[CB-1:0];
        end else begin
            cross_res = cross_add[CB] ? '1 : cross_add[CB-1:0];
        end
        len_add  = {1'b0, length_sum_reg} + (LB+1)'(root);
        acc_add  = {64'b0, prod} << {shift_reg, 5'b0};
        cnt_wide = 32'(count_seen_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mpp_reg        <= pap_pkg::MPP_RESET;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            cross_sum_reg  <= '0;
            length_sum_reg <= '0;
            count_seen_reg <= '0;
            last_reg       <= 1'b0;
            close_reg      <= 1'b0;
            acc_en_reg     <= 1'b0;
            shift_reg      <= 2'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mpp_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && (state_reg != ST_FOUT)) begin
                m_valid_reg <= 1'b0;
            end

            acc_en_reg <= acc_en_next;
            shift_reg  <= shift_next;
            if (acc_en_reg) begin
                acc_reg <= acc_reg + acc_add[AB-1:0];
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cur_x_reg  <= s_vertex_x;
                        cur_y_reg  <= s_vertex_y;
                        last_reg   <= s_last_vertex;
                        prev_x_reg <= s_vertex_x;
                        prev_y_reg <= s_vertex_y;
                        eb_x_reg   <= s_vertex_x;
                        eb_y_reg   <= s_vertex_y;
                        if (count_seen_reg != '1) begin
                            count_seen_reg <= count_seen_reg + COUNT_BITS'(1);
                        end
                        if (count_seen_reg == '0) begin
                            first_x_reg <= s_vertex_x;
                            first_y_reg <= s_vertex_y;
                            ea_x_reg    <= s_vertex_x;
                            ea_y_reg    <= s_vertex_y;
                            close_reg   <= 1'b1;
                            if (s_last_vertex) begin
                                state_reg <= ST_EP;
                            end
                        end else begin
                            ea_x_reg  <= prev_x_reg;
                            ea_y_reg  <= prev_y_reg;
                            close_reg <= 1'b0;
                            state_reg <= ST_EP;
                        end
                    end
                end
                ST_EP: begin
                    dx_reg    <= (ea_x_reg > eb_x_reg) ? (ea_x_reg - eb_x_reg)
                                                       : (eb_x_reg - ea_x_reg);
                    dy_reg    <= (ea_y_reg > eb_y_reg) ? (ea_y_reg - eb_y_reg)
                                                       : (eb_y_reg - ea_y_reg);
                    state_reg <= ST_EQ;
                end
                ST_EQ: begin
                    p_reg     <= prod[PROD_W-1:0];
                    state_reg <= ST_EDX;
                end
                ST_EDX: begin
                    neg_reg   <= pq_neg;
                    dmag_reg  <= CB'(pq_mag);
                    state_reg <= ST_EDY;
                end
                ST_EDY: begin
                    cross_sum_reg <= cross_res ^ SIGN_BIT;
                    sq_reg        <= SQ_W'(prod[PROD_W-1:0]);
                    state_reg     <= ST_ESQ;
                end
                ST_ESQ: begin
                    sq_reg    <= sq_reg + SQ_W'(prod[PROD_W-1:0]);
                    state_reg <= ST_ESTART;
                end
                ST_ESTART: begin
                    state_reg <= ST_EWAIT;
                end
                ST_EWAIT: begin
                    if (sqrt_stat.done) begin
                        length_sum_reg <= len_add[LB] ? '1 : len_add[LB-1:0];
                        if (close_reg) begin
                            state_reg <= ST_FM2;
                        end else if (last_reg) begin
                            ea_x_reg  <= cur_x_reg;
                            ea_y_reg  <= cur_y_reg;
                            eb_x_reg  <= first_x_reg;
                            eb_y_reg  <= first_y_reg;
                            close_reg <= 1'b1;
                            state_reg <= ST_EP;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FM2: begin
                    amag_reg  <= cross_sum_reg[CB-1] ? (~cross_sum_reg + CB'(1))
                                                     : cross_sum_reg;
                    acc_reg   <= '0;
                    state_reg <= ST_FM2W;
                end
                ST_FM2W: begin
                    m2_reg    <= prod[47:0];
                    state_reg <= ST_FA0;
                end
                ST_FA0: state_reg <= ST_FA1;
                ST_FA1: state_reg <= ST_FA2;
                ST_FA2: state_reg <= ST_FA3;
                ST_FA3: state_reg <= ST_FA4;
                ST_FA4: state_reg <= ST_FP0;
                ST_FP0: begin
                    area_res_reg <= (|acc_reg[AB-1:96]) ? '1 : acc_reg[95:33];
                    acc_reg      <= '0;
                    state_reg    <= ST_FP1;
                end
                ST_FP1: state_reg <= ST_FP2;
                ST_FP2: state_reg <= ST_FOUT;
                ST_FOUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_area_reg     <= area_res_reg;
                        m_perim_reg    <= (|acc_reg[AB-1:64]) ? '1 : acc_reg[63:16];
                        m_count_reg    <= (cnt_wide > 32'hFFFF) ? '1 : cnt_wide[15:0];
                        first_x_reg    <= '0;
                        first_y_reg    <= '0;
                        prev_x_reg     <= '0;
                        prev_y_reg     <= '0;
                        cross_sum_reg  <= '0;
                        length_sum_reg <= '0;
                        count_seen_reg <= '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_area_um2     = m_area_reg;
    assign m_perimeter_um = m_perim_reg;
    assign m_vertex_count = m_count_reg;

`ifndef ASSERT_OFF
    a_idle_sqrt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sqrt_stat.busy)
        else $error("square root busy while accepting vertices");

    a_sqrt_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_stat.done |-> (state_reg == ST_EWAIT))
        else $error("square root finished outside the wait step");

    a_empty_contour_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_seen_reg == '0) |-> (cross_sum_reg == '0 && length_sum_reg == '0))
        else $error("sums not clear with no open contour");

    a_result_from_final: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FOUT))
        else $error("result raised outside the final step");
`endif

endmodule
